@@ rtl/dfcm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfcm_pkg
// Shared types, codes and helper functions of the depth false-color mapper.
// ----------------------------------------------------------------------------
package dfcm_pkg;

	// Field widths.
	localparam int unsigned DistW  = 16;
	localparam int unsigned GapW   = 9;
	localparam int unsigned LevelW = 11;
	localparam int unsigned RgbaW  = 32;

	// The quotient is built one bit per cell, one cell per dividend bit.
	localparam int unsigned DivCells = DistW;

	// Reciprocal of the entry count, scaled by 2**RecipShift and rounded up.
	localparam int unsigned RecipW     = 21;
	localparam int unsigned RecipShift = 28;

	// Number of levels in each 255-step ramp segment.
	localparam logic [LevelW-1:0] SegSteps = 11'd255;

	// Ramp selection codes; the spare code behaves as gray.
	localparam logic [1:0] RAMP_HUE   = 2'd0;
	localparam logic [1:0] RAMP_RGB   = 2'd1;
	localparam logic [1:0] RAMP_GRAY  = 2'd2;
	localparam logic [1:0] RAMP_SPARE = 2'd3;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_RAMP_SEL        = 3'd0;
	localparam logic [2:0] REG_MAX_DISTANCE    = 3'd1;
	localparam logic [2:0] REG_OVERFLOW_CODE   = 3'd2;
	localparam logic [2:0] REG_SATURATION_CODE = 3'd3;
	localparam logic [2:0] REG_OVERFLOW_RGBA   = 3'd4;
	localparam logic [2:0] REG_SATURATION_RGBA = 3'd5;
	localparam logic [2:0] REG_INVALID_RGBA    = 3'd6;

	// Register reset values.
	localparam logic [DistW-1:0] MaxDistReset = 16'd16000;
	localparam logic [DistW-1:0] OvfCodeReset = 16'd16001;
	localparam logic [DistW-1:0] SatCodeReset = 16'd16002;
	localparam logic [GapW-1:0]  GapReset     = GapW'(16000 / 1275);

	// Pixel class codes.
	typedef enum logic [1:0] {
		CLS_VALID      = 2'd0,
		CLS_OVERFLOW   = 2'd1,
		CLS_SATURATION = 2'd2,
		CLS_INVALID    = 2'd3
	} pixel_class_t;

	// Partial division result handed from one cell to the next.
	typedef struct packed {
		pixel_class_t     cls;
		logic [DistW-1:0] num;
		logic [GapW-1:0]  rem;
		logic [DistW-1:0] quo;
	} div_beat_t;

	// Total ramp levels for a ramp selection.
	function automatic logic [LevelW-1:0] entry_count(input logic [1:0] mode);
		logic [LevelW-1:0] n;
		case (mode)
			RAMP_HUE: n = 11'd1275;
			RAMP_RGB: n = 11'd510;
			default:  n = 11'd255;
		endcase
		return n;
	endfunction

	// Scaled reciprocal of the entry count; exact for every 16-bit dividend.
	function automatic logic [RecipW-1:0] gap_recip(input logic [1:0] mode);
		logic [RecipW-1:0] r;
		case (mode)
			RAMP_HUE: r = 21'd210538;
			RAMP_RGB: r = 21'd526345;
			default:  r = 21'd1052689;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/dfcm_div_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfcm_div_cell
// One cell of the restoring divider chain: brings down one dividend bit,
// subtracts the gap when it fits and hands the partial result onward.
// ----------------------------------------------------------------------------
module dfcm_div_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic                       in_vld,
	input  wire dfcm_pkg::div_beat_t        in_beat,
	input  wire logic [dfcm_pkg::GapW-1:0]  gap,
	output logic                            out_vld,
	output dfcm_pkg::div_beat_t             out_beat
);

	logic [dfcm_pkg::GapW:0]   shifted;
	logic [dfcm_pkg::GapW:0]   diff;
	logic                      fits;
	dfcm_pkg::div_beat_t       nxt;
	logic                      vld_q;
	dfcm_pkg::div_beat_t       beat_q;

	// Shift in the next dividend bit and try one subtraction.
	always_comb begin
		shifted  = {in_beat.rem, in_beat.num[dfcm_pkg::DistW-1]};
		fits     = shifted >= {1'b0, gap};
		diff     = shifted - {1'b0, gap};
		nxt.cls  = in_beat.cls;
		nxt.num  = {in_beat.num[dfcm_pkg::DistW-2:0], 1'b0};
		nxt.rem  = fits ? diff[dfcm_pkg::GapW-1:0] : shifted[dfcm_pkg::GapW-1:0];
		nxt.quo  = {in_beat.quo[dfcm_pkg::DistW-2:0], fits};
	end

	// Valid flag of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_vld;
		end
	end

	// Payload of this cell.
	always_ff @(posedge clk) begin
		if (adv) begin
			beat_q <= nxt;
		end
	end

	assign out_vld  = vld_q;
	assign out_beat = beat_q;

endmodule

`default_nettype wire

@@ rtl/dfcm_gap_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfcm_gap_unit
// Works out the distance step per ramp level, max_distance / entries, by a
// reciprocal multiplication in the cycle after a register write.
// ----------------------------------------------------------------------------
module dfcm_gap_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [dfcm_pkg::DistW-1:0]   num,
	input  wire logic [1:0]                   mode,
	output logic                              busy,
	output logic [dfcm_pkg::GapW-1:0]         gap
);

	logic                                            busy_q;
	logic [dfcm_pkg::DistW-1:0]                      num_q;
	logic [dfcm_pkg::RecipW-1:0]                     recip_q;
	logic [dfcm_pkg::GapW-1:0]                       gap_q;
	logic [dfcm_pkg::DistW+dfcm_pkg::RecipW-1:0]     prod;

	// Scaled product; its upper bits are the quotient.
	always_comb begin
		prod = num_q * recip_q;
	end

	// Control: a write captures the operands, the next cycle stores the gap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			gap_q  <= dfcm_pkg::GapReset;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			busy_q <= 1'b0;
			gap_q  <= prod[dfcm_pkg::RecipShift +: dfcm_pkg::GapW];
		end
	end

	// Operand registers.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q   <= num;
			recip_q <= dfcm_pkg::gap_recip(mode);
		end
	end

	assign busy = busy_q;
	assign gap  = gap_q;

endmodule

`default_nettype wire

@@ rtl/depth_false_color_mapper.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// depth_false_color_mapper
// Maps 16-bit depth pixels to RGBA false colors and a pixel class.
//
//   channel  direction  payload
//   s_*      in         tdata[15:0] distance
//   m_*      out        tdata: red, green, blue, alpha; tuser: pixel_class
//   wr_*     in         register index and 32-bit write data
//
// One pixel beat is taken per cycle unless m_tready or a gap update stalls it.
// 16 divider cells produce one quotient bit each, then the output register.
// After reset the registers hold their reset values and no clearing runs.
// A write to the ramp selection or max_distance holds s_tready low from the
// cycle after the write while the step per level is recomputed.
// A stall on m_tready freezes the whole cell chain; no beat is lost.
// ----------------------------------------------------------------------------
module depth_false_color_mapper (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Pixel input: tdata = distance[15:0].
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [15:0]  s_tdata,
	// Color output: tdata = red[7:0], green[15:8], blue[23:16], alpha[31:24].
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [31:0]       m_tdata,
	// tuser = pixel_class[1:0].
	output logic [1:0]        m_tuser,
	// Configuration write port.
	input  wire logic         wr_en,
	input  wire logic [2:0]   wr_index,
	input  wire logic [31:0]  wr_data
);

	localparam int unsigned N = dfcm_pkg::DivCells;

	logic [1:0]                       mode_q;
	logic [dfcm_pkg::DistW-1:0]       maxd_q;
	logic [dfcm_pkg::DistW-1:0]       ovf_code_q;
	logic [dfcm_pkg::DistW-1:0]       sat_code_q;
	logic [dfcm_pkg::RgbaW-1:0]       ovf_rgba_q;
	logic [dfcm_pkg::RgbaW-1:0]       sat_rgba_q;
	logic [dfcm_pkg::RgbaW-1:0]       inv_rgba_q;

	logic                             adv;
	logic                             gap_busy;
	logic [dfcm_pkg::GapW-1:0]        gap;
	logic                             gap_start;
	logic [dfcm_pkg::DistW-1:0]       gap_num;
	logic [1:0]                       gap_mode;

	logic                             vld_c [N+1];
	dfcm_pkg::div_beat_t              beat_c [N+1];

	logic [dfcm_pkg::LevelW-1:0]      entries;
	logic [dfcm_pkg::LevelW-1:0]      level;
	logic [dfcm_pkg::LevelW-1:0]      base;
	logic [dfcm_pkg::LevelW-1:0]      level_off;
	logic [2:0]                       seg;
	logic [7:0]                       k;
	logic                             gray;
	logic [7:0]                       red;
	logic [7:0]                       green;
	logic [7:0]                       blue;
	logic [7:0]                       alpha;
	logic [dfcm_pkg::RgbaW-1:0]       fixed_rgba;
	dfcm_pkg::div_beat_t              last;

	logic                             m_tvalid_q;
	logic [31:0]                      m_tdata_q;
	logic [1:0]                       m_tuser_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= dfcm_pkg::RAMP_HUE;
			maxd_q     <= dfcm_pkg::MaxDistReset;
			ovf_code_q <= dfcm_pkg::OvfCodeReset;
			sat_code_q <= dfcm_pkg::SatCodeReset;
			ovf_rgba_q <= '0;
			sat_rgba_q <= '0;
			inv_rgba_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				dfcm_pkg::REG_RAMP_SEL:        mode_q     <= wr_data[1:0];
				dfcm_pkg::REG_MAX_DISTANCE:    maxd_q     <= wr_data[15:0];
				dfcm_pkg::REG_OVERFLOW_CODE:   ovf_code_q <= wr_data[15:0];
				dfcm_pkg::REG_SATURATION_CODE: sat_code_q <= wr_data[15:0];
				dfcm_pkg::REG_OVERFLOW_RGBA:   ovf_rgba_q <= wr_data;
				dfcm_pkg::REG_SATURATION_RGBA: sat_rgba_q <= wr_data;
				dfcm_pkg::REG_INVALID_RGBA:    inv_rgba_q <= wr_data;
				default: ;
			endcase
		end
	end

	// A write that changes the ramp size or range restarts the gap unit
	// with the value being written.
	always_comb begin
		gap_start = wr_en && (wr_index == dfcm_pkg::REG_RAMP_SEL ||
			wr_index == dfcm_pkg::REG_MAX_DISTANCE);
		gap_num   = (wr_index == dfcm_pkg::REG_MAX_DISTANCE) ? wr_data[15:0] : maxd_q;
		gap_mode  = (wr_index == dfcm_pkg::REG_RAMP_SEL) ? wr_data[1:0] : mode_q;
	end

	dfcm_gap_unit u_gap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gap_start),
		.num    (gap_num),
		.mode   (gap_mode),
		.busy   (gap_busy),
		.gap    (gap)
	);

	// The chain moves whenever the output register is free or being emptied.
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv && !gap_busy;

	// Classify the incoming pixel and seed the divider chain.
	always_comb begin
		vld_c[0]       = s_tvalid && !gap_busy;
		beat_c[0].num  = s_tdata;
		beat_c[0].rem  = '0;
		beat_c[0].quo  = '0;
		if (s_tdata < maxd_q) begin
			beat_c[0].cls = dfcm_pkg::CLS_VALID;
		end else if (s_tdata == ovf_code_q) begin
			beat_c[0].cls = dfcm_pkg::CLS_OVERFLOW;
		end else if (s_tdata == sat_code_q) begin
			beat_c[0].cls = dfcm_pkg::CLS_SATURATION;
		end else begin
			beat_c[0].cls = dfcm_pkg::CLS_INVALID;
		end
	end

	// Row of divider cells: cell i works on dividend bit 15-i.
	for (genvar i = 0; i < N; i++) begin : g_cell
		dfcm_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_vld   (vld_c[i]),
			.in_beat  (beat_c[i]),
			.gap      (gap),
			.out_vld  (vld_c[i+1]),
			.out_beat (beat_c[i+1])
		);
	end

	// Clamp the quotient to a level and split it into segment and step.
	always_comb begin
		last    = beat_c[N];
		entries = dfcm_pkg::entry_count(mode_q);
		if (gap == '0 || last.quo >= {5'd0, entries}) begin
			level = entries - 11'd1;
		end else begin
			level = last.quo[dfcm_pkg::LevelW-1:0];
		end
		if (level < dfcm_pkg::SegSteps) begin
			seg  = 3'd0;
			base = 11'd0;
		end else if (level < 11'd510) begin
			seg  = 3'd1;
			base = 11'd255;
		end else if (level < 11'd765) begin
			seg  = 3'd2;
			base = 11'd510;
		end else if (level < 11'd1020) begin
			seg  = 3'd3;
			base = 11'd765;
		end else begin
			seg  = 3'd4;
			base = 11'd1020;
		end
		level_off = level - base;
		k         = level_off[7:0] + 8'd1;
		gray      = (mode_q != dfcm_pkg::RAMP_HUE) && (mode_q != dfcm_pkg::RAMP_RGB);
	end

	// Ramp color or fixed color by class.
	always_comb begin
		case (last.cls)
			dfcm_pkg::CLS_OVERFLOW:   fixed_rgba = ovf_rgba_q;
			dfcm_pkg::CLS_SATURATION: fixed_rgba = sat_rgba_q;
			default:                  fixed_rgba = inv_rgba_q;
		endcase
		if (last.cls == dfcm_pkg::CLS_VALID) begin
			alpha = 8'hFF;
			if (gray) begin
				red   = k;
				green = k;
				blue  = k;
			end else begin
				case (seg)
					3'd0, 3'd3: begin
						red   = k;
						green = k;
						blue  = 8'd255 - k;
					end
					3'd1, 3'd4: begin
						red   = 8'd255;
						green = 8'd255 - k;
						blue  = 8'd0;
					end
					default: begin
						red   = 8'd255 - k;
						green = 8'd0;
						blue  = k;
					end
				endcase
			end
		end else begin
			red   = fixed_rgba[31:24];
			green = fixed_rgba[23:16];
			blue  = fixed_rgba[15:8];
			alpha = fixed_rgba[7:0];
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= vld_c[N];
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= {alpha, blue, green, red};
			m_tuser_q <= last.cls;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	// No pixel is taken while the gap is being recomputed.
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		gap_busy |-> !s_tready)
		else $error("pixel accepted during gap update");

	// A write to max_distance stalls the input in the next cycle.
	a_write_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && wr_index == dfcm_pkg::REG_MAX_DISTANCE |=> !s_tready)
		else $error("gap update did not stall input");

	// Ramp colors are always opaque.
	a_ramp_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == dfcm_pkg::CLS_VALID |-> m_tdata[31:24] == 8'hFF)
		else $error("ramp color not opaque");

	// A stalled output holds the chain, so the output beat keeps its class.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready ##1 (m_tvalid && $stable(m_tuser)))
		else $error("chain advanced during output stall");
`endif

endmodule

`default_nettype wire
